// ===== design/ifla_pkg.sv =====
// Shared constants, codes and types for the index free list allocator.
package ifla_pkg;

	localparam int ENTRIES_DEF   = 64;
	localparam int MAX_GRANT_DEF = 8;
	localparam int RESULT_CAP    = 8;

	localparam int CMD_W      = 1;
	localparam int COUNT_W    = 4;
	localparam int TAG_W      = 16;
	localparam int SLOT_W     = 6;
	localparam int STATUS_W   = 2;
	localparam int FREE_OUT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_SPACE = 2'd1,
		STATUS_NOT_HELD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_REL,
		ST_FAIL
	} state_t;

endpackage

// ===== design/ifla_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
module ifla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/index_free_list_allocator_core.sv =====
// Top level of the index free list allocator: link RAM, slot RAM and sequencer.
// Allocate of N slots: N results, one per slot, each granted from the list head
// (one link RAM read per slot, chained straight off the registered read data).
// Release: slot RAM read, then write back and result. Failed allocate: result from ST_FAIL.
// A waiting result sits in the output register while the next transaction is taken.
// Reset is asynchronous; no clearing pass: a fill count stands in for the initial
// links and held bits, so the block can take a transaction as soon as reset is released.
module index_free_list_allocator_core #(
	parameter int ENTRIES   = ifla_pkg::ENTRIES_DEF,
	parameter int MAX_GRANT = ifla_pkg::MAX_GRANT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ifla_pkg::CMD_W-1:0]    command,
	input  logic [ifla_pkg::COUNT_W-1:0]  request_count,
	input  logic [ifla_pkg::TAG_W-1:0]    owner_tag,
	input  logic [ifla_pkg::SLOT_W-1:0]   slot_index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ifla_pkg::STATUS_W-1:0] status,
	output logic [ifla_pkg::SLOT_W-1:0]   granted_slot,
	output logic [ifla_pkg::TAG_W-1:0]    returned_tag,
	output logic [ifla_pkg::FREE_OUT_W-1:0] free_slots,
	output logic                          last
);

	import ifla_pkg::*;

	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int FILL_W    = $clog2(ENTRIES + 1);
	localparam int CMP_W     = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
	localparam int GRANT_CAP = (MAX_GRANT < RESULT_CAP) ? MAX_GRANT : RESULT_CAP;
	localparam int SRAM_W    = TAG_W + 1;

	// Successor of an entry in the initial list; the final entry links to zero.
	function automatic logic [IDX_W-1:0] succ(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] nxt;
		if (idx == IDX_W'(ENTRIES - 1)) begin
			nxt = '0;
		end else begin
			nxt = idx + 1'b1;
		end
		return nxt;
	endfunction

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t              state_q, state_d;
	logic [IDX_W-1:0]    head_q;      // list head when no link read is pending
	logic                pend_q;      // head comes from the last link read
	logic [FILL_W-1:0]   fill_q;      // entries below this have been handed out once
	logic [FILL_W-1:0]   free_q;
	logic [IDX_W-1:0]    prev_s1;     // entry whose link was read last
	logic                fresh_s1;    // that entry still had its initial link
	logic                out_valid_q;

	// Transaction payload held while it is worked on
	logic [COUNT_W-1:0]  rem_q;
	logic [TAG_W-1:0]    tag_q;
	logic [IDX_W-1:0]    slot_idx_q;
	logic                in_range_q;

	// Output register payload
	status_t             status_q;
	logic [SLOT_W-1:0]   granted_q;
	logic [TAG_W-1:0]    rtag_q;
	logic [FREE_OUT_W-1:0] free_out_q;
	logic                last_q;

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	logic                link_we, link_re;
	logic [IDX_W-1:0]    link_waddr, link_wdata, link_raddr, link_rdata;
	logic                slot_we, slot_re;
	logic [IDX_W-1:0]    slot_waddr, slot_raddr;
	logic [SRAM_W-1:0]   slot_wdata, slot_rdata;

	// next_link: written on release only
	ifla_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// {held, owner tag}: written on every grant and every good release
	ifla_ram #(.WIDTH(SRAM_W), .DEPTH(ENTRIES)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// ------------------------------------------------------------------
	// Effective head. The link RAM only reads while allocating, so its
	// read data holds across output stalls and can feed the head directly.
	// Entries at or above fill_q were never handed out and keep their
	// initial link, which is computed instead of read.
	// ------------------------------------------------------------------
	logic [IDX_W-1:0] link_value, head_eff;
	logic             fresh_now;

	assign link_value = fresh_s1 ? succ(prev_s1) : link_rdata;
	assign head_eff   = pend_q ? link_value : head_q;
	assign fresh_now  = (FILL_W'(head_eff) >= fill_q);

	// ------------------------------------------------------------------
	// Handshake and request checks
	// ------------------------------------------------------------------
	logic in_fire, out_free, alloc_ok, in_range, held_ok;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign alloc_ok = (request_count != '0)
		&& (request_count <= COUNT_W'(GRANT_CAP))
		&& (CMP_W'(free_q) >= CMP_W'(request_count));

	assign in_range = (32'(slot_index) < 32'(ENTRIES));

	// an entry never handed out is not held, whatever the RAM holds
	assign held_ok = in_range_q && (FILL_W'(slot_idx_q) < fill_q) && slot_rdata[TAG_W];

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic             emit, pop, rel_ok;
	status_t          emit_status;
	logic [SLOT_W-1:0] emit_slot;
	logic [TAG_W-1:0] emit_tag;
	logic             emit_last;

	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		emit_status = STATUS_OK;
		emit_slot   = '0;
		emit_tag    = '0;
		emit_last   = 1'b1;
		pop         = 1'b0;
		rel_ok      = 1'b0;
		link_re     = 1'b0;
		link_raddr  = head_eff;
		link_we     = 1'b0;
		link_waddr  = slot_idx_q;
		link_wdata  = head_eff;
		slot_re     = 1'b0;
		slot_raddr  = IDX_W'(slot_index);
		slot_we     = 1'b0;
		slot_waddr  = head_eff;
		slot_wdata  = {1'b1, tag_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (command == CMD_ALLOC) begin
						state_d = alloc_ok ? ST_ALLOC : ST_FAIL;
					end else begin
						slot_re = 1'b1;
						state_d = ST_REL;
					end
				end
			end
			ST_ALLOC: begin
				// one slot per cycle while the output is not stalled: grant the head, read its link
				if (out_free) begin
					emit      = 1'b1;
					emit_slot = SLOT_W'(head_eff);
					emit_last = (rem_q == COUNT_W'(1));
					pop       = 1'b1;
					link_re   = 1'b1;
					slot_we   = 1'b1;
					if (rem_q == COUNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_REL: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (held_ok) begin
						emit_tag   = slot_rdata[TAG_W-1:0];
						rel_ok     = 1'b1;
						slot_we    = 1'b1;
						slot_waddr = slot_idx_q;
						slot_wdata = {1'b0, slot_rdata[TAG_W-1:0]};
						link_we    = 1'b1;
					end else begin
						emit_status = STATUS_NOT_HELD;
					end
				end
			end
			ST_FAIL: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = STATUS_NO_SPACE;
					state_d     = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			pend_q      <= 1'b0;
			fill_q      <= '0;
			free_q      <= FILL_W'(ENTRIES);
			fresh_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && (command == CMD_ALLOC) && alloc_ok) begin
				// free count drops at once: every result of the run reports it
				free_q <= free_q - FILL_W'(request_count);
			end else if (rel_ok) begin
				free_q <= free_q + 1'b1;
			end
			if (pop) begin
				pend_q   <= 1'b1;
				fresh_s1 <= fresh_now;
				if (fresh_now) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (rel_ok) begin
				pend_q <= 1'b0;
				head_q <= slot_idx_q;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rem_q      <= request_count;
			tag_q      <= owner_tag;
			slot_idx_q <= IDX_W'(slot_index);
			in_range_q <= in_range;
		end else if (pop) begin
			rem_q <= rem_q - 1'b1;
		end
		if (pop) begin
			prev_s1 <= head_eff;
		end
		if (emit) begin
			status_q   <= emit_status;
			granted_q  <= emit_slot;
			rtag_q     <= emit_tag;
			free_out_q <= FREE_OUT_W'(rel_ok ? free_q + 1'b1 : free_q);
			last_q     <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign returned_tag = rtag_q;
	assign free_slots   = free_out_q;
	assign last         = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FILL_W'(ENTRIES))
		else $error("free count above pool size");

	// entries never handed out are all still on the list; during an allocate
	// run the slots not yet popped are still on it too
	a_untouched_free: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(ENTRIES) - int'(fill_q))
			<= (int'(free_q) + ((state_q == ST_ALLOC) ? int'(rem_q) : 0)))
		else $error("free count below number of untouched entries");

	a_alloc_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |-> (rem_q != '0))
		else $error("allocate run with no slots left to grant");

endmodule
